[hw/rtl/qodr_pkg.sv]
// ----------------------------------------------------------------------------
// qodr_pkg
// Shared types, constants and the arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package qodr_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam int ITER_W            = 5;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 32;
    localparam int DPC_W             = 24;
    localparam int APC_W             = 32;
    localparam int MUL_W             = 33;
    localparam int PROD_W            = 2 * MUL_W;
    localparam int VEC_W             = 35;
    localparam int ANG_W             = 34;

    // Inverse CORDIC gain in Q30.
    localparam logic signed [MUL_W-1:0] GAIN_INV_Q30 = 33'sd652032874;

    localparam logic [1:0] OP_LEFT   = 2'd0;
    localparam logic [1:0] OP_RIGHT  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PER_COUNT = 1'd1;

    typedef struct packed {
        logic [1:0] operation;
        logic       phase_a;
        logic       phase_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic        [31:0] pose_heading;
    } pose_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_SUM,
        ST_GAIN,
        ST_INIT,
        ST_ROT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_DL,
        MUL_DR,
        MUL_GAIN,
        MUL_TURN
    } mul_sel_t;

    typedef struct packed {
        logic              count_en;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              load_pl;
        logic              load_d;
        logic              init;
        logic              rotate;
        logic              finish;
        logic [ITER_W-1:0] iter;
    } dp_cmd_t;

    // Arctangent of 2^-i, full turn equals 2^32.
    function automatic logic [31:0] atan_turns(input logic [ITER_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/qodr_ctrl.sv]
// ----------------------------------------------------------------------------
// qodr_ctrl
// Sequencer for edge counting and the per-tick pose update.
// ----------------------------------------------------------------------------
module qodr_ctrl #(
    parameter int CORDIC_STAGES = qodr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    output logic                out_valid,
    input  logic                out_ready,
    output qodr_pkg::dp_cmd_t   cmd
);
    import qodr_pkg::*;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STAGES - 1);

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              slot_free;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && operation == OP_TICK) state_next = ST_MUL_L;
            ST_MUL_L:  state_next = ST_MUL_R;
            ST_MUL_R:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_INIT;
            ST_INIT:   state_next = ST_ROT;
            ST_ROT:    if (iter_reg == ITER_LAST) state_next = ST_FINISH;
            ST_FINISH: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd          = '0;
        cmd.mul_sel  = MUL_DL;
        cmd.iter     = iter_reg;
        iter_next    = iter_reg;
        unique case (state_reg)
            ST_IDLE:   cmd.count_en = accept;
            ST_MUL_L:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DL;
            end
            ST_MUL_R:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DR;
                cmd.load_pl = 1'b1;
            end
            ST_SUM:    cmd.load_d = 1'b1;
            ST_GAIN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
            end
            ST_INIT:
            begin
                cmd.init    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TURN;
                iter_next   = '0;
            end
            ST_ROT:
            begin
                cmd.rotate = 1'b1;
                iter_next  = iter_reg + 1'b1;
            end
            ST_FINISH: cmd.finish = slot_free;
            default:   cmd = '0;
        endcase
        out_valid_next = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("pose written over an unread result");

    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT) |-> (iter_reg <= ITER_LAST))
        else $error("rotation index past last stage");

    a_rose_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT) |=> !in_ready || (state_reg == ST_IDLE))
        else $error("request taken during rotation");

endmodule

[hw/rtl/qodr_dp.sv]
// ----------------------------------------------------------------------------
// qodr_dp
// Counters, shared multiplier, CORDIC rotator and pose accumulators.
// ----------------------------------------------------------------------------
module qodr_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  qodr_pkg::dp_cmd_t               cmd,
    input  qodr_pkg::in_item_t              in_data,
    input  logic                            cfg_we,
    input  logic [qodr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qodr_pkg::CFG_DATA_W-1:0] cfg_data,
    output qodr_pkg::pose_t                 out_data
);
    import qodr_pkg::*;

    logic [DPC_W-1:0]         dpc_reg;
    logic [APC_W-1:0]         apc_reg;
    logic [31:0]              left_total_reg, right_total_reg;
    logic [31:0]              left_last_reg, right_last_reg;
    logic [31:0]              x_pos_reg, y_pos_reg, heading_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MUL_W-1:0]         pl_reg;
    logic [31:0]              d_reg;
    logic signed [VEC_W-1:0]  x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;

    logic [31:0]              dl, dr, diff;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic [MUL_W-1:0]         sum;
    logic signed [VEC_W-1:0]  v0, xs, ys;
    logic [15:0]              a_raw, a_adj;
    logic                     flip;
    logic signed [ANG_W-1:0]  atan_ext;
    logic                     same;

    assign dl   = left_total_reg - left_last_reg;
    assign dr   = right_total_reg - right_last_reg;
    assign diff = dr - dl;
    assign same = (in_data.phase_a == in_data.phase_b);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DL:
            begin
                mul_a = MUL_W'(signed'(dl));
                mul_b = signed'({{(MUL_W-DPC_W){1'b0}}, dpc_reg});
            end
            MUL_DR:
            begin
                mul_a = MUL_W'(signed'(dr));
                mul_b = signed'({{(MUL_W-DPC_W){1'b0}}, dpc_reg});
            end
            MUL_GAIN:
            begin
                mul_a = MUL_W'(signed'(d_reg));
                mul_b = GAIN_INV_Q30;
            end
            default:
            begin
                mul_a = MUL_W'(signed'(diff));
                mul_b = signed'({1'b0, apc_reg});
            end
        endcase
    end

    // Only bit 32 and below of each product feed the halved sum.
    assign sum = pl_reg + prod_reg[MUL_W-1:0];

    assign v0       = VEC_W'(signed'(prod_reg[63:30]));
    assign a_raw    = heading_reg[31:16];
    assign flip     = a_raw[15] ^ a_raw[14];
    assign a_adj    = flip ? (a_raw + 16'h8000) : a_raw;
    assign xs       = x_reg >>> cmd.iter;
    assign ys       = y_reg >>> cmd.iter;
    assign atan_ext = ANG_W'(signed'({1'b0, atan_turns(cmd.iter)}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpc_reg         <= '0;
            apc_reg         <= '0;
            left_total_reg  <= '0;
            right_total_reg <= '0;
            left_last_reg   <= '0;
            right_last_reg  <= '0;
            x_pos_reg       <= '0;
            y_pos_reg       <= '0;
            heading_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIST_PER_COUNT:  dpc_reg <= cfg_data[DPC_W-1:0];
                    REG_ANGLE_PER_COUNT: apc_reg <= cfg_data[APC_W-1:0];
                    default:             dpc_reg <= dpc_reg;
                endcase
            end
            if (cmd.count_en && in_data.operation == OP_LEFT)
                left_total_reg <= same ? left_total_reg - 1'b1 : left_total_reg + 1'b1;
            if (cmd.count_en && in_data.operation == OP_RIGHT)
                right_total_reg <= same ? right_total_reg - 1'b1 : right_total_reg + 1'b1;
            if (cmd.finish)
            begin
                x_pos_reg      <= x_pos_reg + x_reg[31:0];
                y_pos_reg      <= y_pos_reg + y_reg[31:0];
                heading_reg    <= heading_reg + prod_reg[47:16];
                left_last_reg  <= left_total_reg;
                right_last_reg <= right_total_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.load_pl)
            pl_reg <= prod_reg[MUL_W-1:0];
        if (cmd.load_d)
            d_reg <= sum[32:1];
        if (cmd.init)
        begin
            x_reg <= flip ? -v0 : v0;
            y_reg <= '0;
            z_reg <= ANG_W'(signed'({a_adj, 16'h0000}));
        end
        else if (cmd.rotate)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_ext;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_ext;
            end
        end
    end

    assign out_data.pose_x       = signed'(x_pos_reg);
    assign out_data.pose_y       = signed'(y_pos_reg);
    assign out_data.pose_heading = heading_reg;

endmodule

[hw/rtl/quadrature_odometry_dead_reckoning_top.sv]
// ----------------------------------------------------------------------------
// quadrature_odometry_dead_reckoning_top
// Differential-drive odometry from quadrature edges with CORDIC pose update.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready/in_data) carries one request per
// encoder edge or sample tick. Edge requests are counted as they are taken
// and produce no result. A tick request runs the pose update: two distance
// products, the halved sum, gain compensation, the turn product with the
// rotator load, one CORDIC rotation per stage and a final accumulate that
// writes the pose to out_data. The multiplier is shared by all products
// and the rotator is a single iterative stage; a new request is taken once
// the update finishes. The pose sits in an output register, so edges keep
// being counted while it waits; only a following tick waits in its final
// step until the previous pose is taken. The user writes the scale
// registers via the config port (cfg_we/cfg_index/cfg_data) only while
// no tick is in flight; the block itself does not enforce this. Reset
// clears all counts, the pose and both scale registers.
// ----------------------------------------------------------------------------
module quadrature_odometry_dead_reckoning_top #(
    parameter int CORDIC_STAGES = qodr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  qodr_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output qodr_pkg::pose_t                 out_data,
    input  logic                            cfg_we,
    input  logic [qodr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qodr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import qodr_pkg::*;

    dp_cmd_t cmd;

    qodr_ctrl #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (in_data.operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    qodr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
